// ----- src/n2a_pkg.sv -----
// Shared types, codes and helper functions for the number-to-ASCII formatter.
`timescale 1ns / 1ps
package n2a_pkg;

    // Default number width and fixed field widths
    localparam int NUMBER_WIDTH_DEF = 32;
    localparam int VALUE_W          = 32;
    localparam int QUEUE_DEPTH      = 2;
    localparam int MAX_CHARS        = 32;

    // Radix modes
    localparam logic [1:0] FUNC_UDEC = 2'd0;
    localparam logic [1:0] FUNC_SDEC = 2'd1;
    localparam logic [1:0] FUNC_HEX  = 2'd2;
    localparam logic [1:0] FUNC_BIN  = 2'd3;

    // Character codes
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_A     = 7'h41;

    // Request word
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] value;
        logic [5:0]  digit_count;
        logic [2:0]  line;
        logic [4:0]  start_column;
    } in_word_t;

    // Character word
    typedef struct packed {
        logic [2:0] out_line;
        logic [5:0] out_column;
        logic [6:0] char_code;
        logic       last;
    } out_word_t;

    // Classified request passed from front to back (magnitude travels beside it)
    typedef struct packed {
        logic [1:0] func;
        logic       neg;
        logic [5:0] len;
        logic [2:0] line;
        logic [4:0] col;
    } cmd_info_t;

    // Decimal digits of the largest w-bit unsigned value (elaboration only)
    function automatic int dec_digits(input int w);
        logic [63:0] m;
        int          n;
        m = (w >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << w) - 64'd1);
        n = 0;
        for (int k = 0; k < 20; k++) begin
            if (m != 64'd0) begin
                m = m / 64'd10;
                n = n + 1;
            end
        end
        return n;
    endfunction

    // Digit value to ASCII: 0-9 then uppercase A-F
    function automatic logic [6:0] ascii_digit(input logic [3:0] d);
        logic [6:0] code;
        if (d < 4'd10)
            code = CH_ZERO + 7'(d);
        else
            code = CH_A + 7'(d) - 7'd10;
        return code;
    endfunction

endpackage

// ----- src/n2a_front.sv -----
// Front part: takes a request, saturates the digit count, splits off the sign.
`timescale 1ns / 1ps
module n2a_front #(
    parameter int NUMBER_WIDTH = n2a_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                     req_valid,
    output logic                     req_stall,
    input  n2a_pkg::in_word_t        req,
    input  logic                     full,
    output logic                     push,
    output n2a_pkg::cmd_info_t       info,
    output logic [NUMBER_WIDTH-1:0]  mag
);
    import n2a_pkg::*;

    localparam int DEC_D   = dec_digits(NUMBER_WIDTH);
    localparam int DEC_LIM = (DEC_D > MAX_CHARS - 1) ? MAX_CHARS - 1 : DEC_D;
    localparam int HEX_D   = (NUMBER_WIDTH + 3) / 4;
    localparam int HEX_LIM = (HEX_D > MAX_CHARS - 1) ? MAX_CHARS - 1 : HEX_D;
    localparam int BIN_LIM = (NUMBER_WIDTH > MAX_CHARS) ? MAX_CHARS : NUMBER_WIDTH;

    logic [NUMBER_WIDTH-1:0] v;
    logic [5:0]              lim;
    logic                    neg;

    // Number seen at the configured width
    generate
        if (NUMBER_WIDTH <= VALUE_W) begin : g_trunc
            assign v = req.value[NUMBER_WIDTH-1:0];
        end else begin : g_ext
            assign v = {{(NUMBER_WIDTH-VALUE_W){1'b0}}, req.value};
        end
    endgenerate

    // Queue back-pressure
    assign req_stall = full;
    assign push      = req_valid && !full;

    // Classification
    always_comb
    begin
        case (req.func)
            FUNC_HEX: lim = 6'(HEX_LIM);
            FUNC_BIN: lim = 6'(BIN_LIM);
            default:  lim = 6'(DEC_LIM);
        endcase
        neg = (req.func == FUNC_SDEC) && v[NUMBER_WIDTH-1];
        mag = neg ? (~v + 1'b1) : v;
        info.func = req.func;
        info.neg  = neg;
        info.len  = (req.digit_count > lim) ? lim : req.digit_count;
        info.line = req.line;
        info.col  = req.start_column;
    end

endmodule

// ----- src/n2a_fifo.sv -----
// Short command queue between the front and back parts.
`timescale 1ns / 1ps
module n2a_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = n2a_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] wdata,
    input  logic          pop,
    output logic [DW-1:0] rdata,
    output logic          full,
    output logic          empty
);
    import n2a_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    // Pointer and fill tracking
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ----- src/n2a_back.sv -----
// Back part: binary-to-BCD conversion and character-by-character emission.
`timescale 1ns / 1ps
module n2a_back #(
    parameter int NUMBER_WIDTH = n2a_pkg::NUMBER_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     empty,
    output logic                     pop,
    input  n2a_pkg::cmd_info_t       info,
    input  logic [NUMBER_WIDTH-1:0]  mag,
    output logic                     chr_valid,
    input  logic                     chr_stall,
    output n2a_pkg::out_word_t       chr
);
    import n2a_pkg::*;

    localparam int DEC_D = dec_digits(NUMBER_WIDTH);
    localparam int BW    = 4 * DEC_D;
    localparam int SW    = (BW > NUMBER_WIDTH) ? BW : NUMBER_WIDTH;
    localparam int CW    = $clog2(NUMBER_WIDTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CONV  = 2'd1;
    localparam logic [1:0] ST_SIGN  = 2'd2;
    localparam logic [1:0] ST_DIGIT = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [1:0]              func_reg, func_next;
    logic                    neg_reg, neg_next;
    logic [5:0]              len_reg, len_next;
    logic [4:0]              pos_reg, pos_next;
    logic [2:0]              line_reg, line_next;
    logic [5:0]              col_reg, col_next;
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [NUMBER_WIDTH-1:0] bin_reg, bin_next;
    logic [BW-1:0]           bcd_reg, bcd_next;
    logic                    chr_valid_reg, chr_valid_next;
    out_word_t               chr_reg, chr_next;

    logic                    emit_ok;
    logic                    is_dec;
    logic [BW-1:0]           bcd_adj;
    logic [SW-1:0]           src;
    logic [SW-1:0]           shifted;
    logic [6:0]              shamt;
    logic [3:0]              digit;

    assign chr_valid = chr_valid_reg;
    assign chr       = chr_reg;

    // Output slot is free when empty or being taken this cycle
    assign emit_ok = !chr_valid_reg || !chr_stall;
    assign is_dec  = (func_reg == FUNC_UDEC) || (func_reg == FUNC_SDEC);
    assign pop     = (state_reg == ST_IDLE) && !empty;

    // Add-3 correction of every BCD digit before the shift
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int k = 0; k < DEC_D; k++) begin
            if (bcd_reg[4*k +: 4] >= 4'd5)
                bcd_adj[4*k +: 4] = bcd_reg[4*k +: 4] + 4'd3;
        end
    end

    // Digit at position pos_reg of the selected radix
    always_comb
    begin
        src     = is_dec ? SW'(bcd_reg) : SW'(bin_reg);
        shamt   = (func_reg == FUNC_BIN) ? {2'b00, pos_reg} : {pos_reg, 2'b00};
        shifted = src >> shamt;
        digit   = (func_reg == FUNC_BIN) ? {3'b000, shifted[0]} : shifted[3:0];
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        func_next      = func_reg;
        neg_next       = neg_reg;
        len_next       = len_reg;
        pos_next       = pos_reg;
        line_next      = line_reg;
        col_next       = col_reg;
        cnt_next       = cnt_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        chr_next       = chr_reg;
        chr_valid_next = emit_ok ? 1'b0 : chr_valid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty) begin
                    func_next = info.func;
                    neg_next  = info.neg;
                    len_next  = info.len;
                    pos_next  = 5'(info.len - 6'd1);
                    line_next = info.line;
                    col_next  = {1'b0, info.col};
                    bin_next  = mag;
                    bcd_next  = '0;
                    cnt_next  = CW'(NUMBER_WIDTH);
                    if ((info.func == FUNC_UDEC) || (info.func == FUNC_SDEC))
                        state_next = ST_CONV;
                    else if (info.len != 6'd0)
                        state_next = ST_DIGIT;
                end
            end

            ST_CONV:
            begin
                bcd_next = {bcd_adj[BW-2:0], bin_reg[NUMBER_WIDTH-1]};
                bin_next = bin_reg << 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    if (func_reg == FUNC_SDEC)
                        state_next = ST_SIGN;
                    else if (len_reg != 6'd0)
                        state_next = ST_DIGIT;
                    else
                        state_next = ST_IDLE;
                end
            end

            ST_SIGN:
            begin
                if (emit_ok) begin
                    chr_valid_next     = 1'b1;
                    chr_next.out_line  = line_reg;
                    chr_next.out_column = col_reg;
                    chr_next.char_code = neg_reg ? CH_MINUS : CH_PLUS;
                    chr_next.last      = (len_reg == 6'd0);
                    col_next           = col_reg + 6'd1;
                    state_next         = (len_reg == 6'd0) ? ST_IDLE : ST_DIGIT;
                end
            end

            ST_DIGIT:
            begin
                if (emit_ok) begin
                    chr_valid_next     = 1'b1;
                    chr_next.out_line  = line_reg;
                    chr_next.out_column = col_reg;
                    chr_next.char_code = ascii_digit(digit);
                    chr_next.last      = (pos_reg == 5'd0);
                    col_next           = col_reg + 6'd1;
                    pos_next           = pos_reg - 5'd1;
                    if (pos_reg == 5'd0)
                        state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            chr_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            chr_valid_reg <= chr_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        neg_reg  <= neg_next;
        len_reg  <= len_next;
        pos_reg  <= pos_next;
        line_reg <= line_next;
        col_reg  <= col_next;
        cnt_reg  <= cnt_next;
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        chr_reg  <= chr_next;
    end

endmodule

// ----- src/number_to_ascii_digit_formatter_core.sv -----
// Top level of the number-to-ASCII digit formatter: front, queue and back.
// Timing: the first character is registered; a decimal request first passes through
//   bit-serial BCD conversion, while hex or binary requests go straight to emission.
// Throughput: the back part takes a new request only once it is done with the last;
//   characters then leave one per cycle while chr_stall is low; queue holds 2.
// Reset: asynchronous, active low; clears the queue, sequencer and output valid.
`timescale 1ns / 1ps
module number_to_ascii_digit_formatter_core #(
    parameter int NUMBER_WIDTH = n2a_pkg::NUMBER_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  n2a_pkg::in_word_t  req,
    output logic               chr_valid,
    input  logic               chr_stall,
    output n2a_pkg::out_word_t chr
);
    import n2a_pkg::*;

    localparam int QW = NUMBER_WIDTH + $bits(cmd_info_t);

    logic                    push;
    logic                    pop;
    logic                    full;
    logic                    empty;
    cmd_info_t               f_info;
    logic [NUMBER_WIDTH-1:0] f_mag;
    cmd_info_t               b_info;
    logic [NUMBER_WIDTH-1:0] b_mag;
    logic [QW-1:0]           q_wdata;
    logic [QW-1:0]           q_rdata;

    assign q_wdata = {f_info, f_mag};
    assign {b_info, b_mag} = q_rdata;

    n2a_front #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_front (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .full      (full),
        .push      (push),
        .info      (f_info),
        .mag       (f_mag)
    );

    n2a_fifo #(
        .DW    (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .pop   (pop),
        .rdata (q_rdata),
        .full  (full),
        .empty (empty)
    );

    n2a_back #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .pop       (pop),
        .info      (b_info),
        .mag       (b_mag),
        .chr_valid (chr_valid),
        .chr_stall (chr_stall),
        .chr       (chr)
    );

endmodule

// ----- src/n2a_checker.sv -----
// Port-level checker for the formatter, bound to the top level.
`timescale 1ns / 1ps
module n2a_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               chr_valid,
    input logic               chr_stall,
    input n2a_pkg::out_word_t chr
);
    import n2a_pkg::*;

    logic       pend_reg, pend_next;
    logic [5:0] exp_col_reg, exp_col_next;
    logic [2:0] exp_line_reg, exp_line_next;

    // Track the position expected for the next character of a run
    always_comb
    begin
        pend_next     = pend_reg;
        exp_col_next  = exp_col_reg;
        exp_line_next = exp_line_reg;
        if (chr_valid && !chr_stall) begin
            pend_next     = !chr.last;
            exp_col_next  = chr.out_column + 6'd1;
            exp_line_next = chr.out_line;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_reg     <= 1'b0;
            exp_col_reg  <= '0;
            exp_line_reg <= '0;
        end else begin
            pend_reg     <= pend_next;
            exp_col_reg  <= exp_col_next;
            exp_line_reg <= exp_line_next;
        end
    end

    // A stalled character word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid && chr_stall |=> chr_valid && $stable(chr))
        else $error("character word changed while stalled");

    // Only digits, hex letters and signs are produced
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid |-> ((chr.char_code >= CH_ZERO) && (chr.char_code <= 7'h39)) ||
                      ((chr.char_code >= CH_A) && (chr.char_code <= 7'h46)) ||
                      (chr.char_code == CH_PLUS) || (chr.char_code == CH_MINUS))
        else $error("illegal character code");

    // Characters of one run sit on one line at consecutive columns
    a_run: assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid && pend_reg |->
            (chr.out_column == exp_col_reg) && (chr.out_line == exp_line_reg))
        else $error("run position broken");

    // A sign only opens a run
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        chr_valid && ((chr.char_code == CH_PLUS) || (chr.char_code == CH_MINUS))
            |-> !pend_reg)
        else $error("sign inside a run");

endmodule

bind number_to_ascii_digit_formatter_core n2a_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .chr_valid (chr_valid),
    .chr_stall (chr_stall),
    .chr       (chr)
);
